// File: rtl/core/bidp_pkg.sv
// Shared types, constants and helper functions for the backlight idle dimming policy.
package bidp_pkg;

	localparam int TIME_BITS = 48;
	localparam int LEVEL_W   = 7;
	localparam int WAIT_W    = 32;
	localparam int OPAC_W    = 8;

	localparam int IN_DATA_W  = 56;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 24;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// n / 100 == (n * 5243) >> 19 for every n below 2^15
	localparam logic [12:0] OPAC_RECIP = 13'd5243;
	localparam int          OPAC_SHIFT = 19;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;

	localparam logic [LEVEL_W-1:0] ACTIVE_LEVEL_RST    = 7'd100;
	localparam logic [LEVEL_W-1:0] IDLE_LEVEL_RST      = 7'd30;
	localparam logic [LEVEL_W-1:0] OFFLINE_LEVEL_RST   = 7'd10;
	localparam logic [WAIT_W-1:0]  DETAIL_HOLD_MS_RST  = 32'd10000;
	localparam logic [WAIT_W-1:0]  IDLE_WAIT_MS_RST    = 32'd30000;
	localparam logic [WAIT_W-1:0]  OFFLINE_WAIT_MS_RST = 32'd60000;

	typedef enum logic [2:0] {
		KIND_RESTART  = 3'd0,
		KIND_SNAPSHOT = 3'd1,
		KIND_TAP      = 3'd2,
		KIND_ACTIVITY = 3'd3,
		KIND_TICK     = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_ACTIVE_LEVEL    = 3'd0,
		REG_IDLE_LEVEL      = 3'd1,
		REG_OFFLINE_LEVEL   = 3'd2,
		REG_DETAIL_HOLD_MS  = 3'd3,
		REG_IDLE_WAIT_MS    = 3'd4,
		REG_OFFLINE_WAIT_MS = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] active_level;
		logic [LEVEL_W-1:0] idle_level;
		logic [LEVEL_W-1:0] offline_level;
		logic [WAIT_W-1:0]  detail_hold_ms;
		logic [WAIT_W-1:0]  idle_wait_ms;
		logic [WAIT_W-1:0]  offline_wait_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic [TIME_BITS-1:0] now_ms;
		logic                 detail_present;
		logic                 in_region;
		logic                 link_up;
		logic                 agent_idle;
	} item_t;

	typedef struct packed {
		logic               level_changed;
		logic               view_changed;
		logic [LEVEL_W-1:0] level_now;
		logic               detail_shown;
		logic [OPAC_W-1:0]  dim_opacity;
	} result_t;

	// Timeout reached only when time has not gone backwards
	function automatic logic waited(input logic [TIME_BITS-1:0] now_t,
		input logic [TIME_BITS-1:0] start_t, input logic [WAIT_W-1:0] wait_ms);
		logic [TIME_BITS-1:0] span;
		begin
			span = now_t - start_t;
			return (now_t >= start_t) &&
				(span >= {{(TIME_BITS-WAIT_W){1'b0}}, wait_ms});
		end
	endfunction

	// round((100 - min(level,100)) * 255 / 100)
	function automatic logic [OPAC_W-1:0] opacity_of(input logic [LEVEL_W-1:0] level);
		logic [LEVEL_W-1:0] lv;
		logic [LEVEL_W-1:0] dark;
		logic [14:0]        num;
		logic [27:0]        prod;
		begin
			lv   = (level > LEVEL_FULL) ? LEVEL_FULL : level;
			dark = LEVEL_FULL - lv;
			num  = {dark, 8'd0} - {8'd0, dark} + 15'd50;
			prod = {13'd0, num} * {15'd0, OPAC_RECIP};
			return prod[OPAC_SHIFT +: OPAC_W];
		end
	endfunction

endpackage

// File: rtl/core/bidp_cfg_regs.sv
// APB configuration register file for the dimming policy.
module bidp_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bidp_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bidp_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bidp_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output bidp_pkg::cfg_t                   cfg
);

	bidp_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level    <= bidp_pkg::ACTIVE_LEVEL_RST;
			cfg_q.idle_level      <= bidp_pkg::IDLE_LEVEL_RST;
			cfg_q.offline_level   <= bidp_pkg::OFFLINE_LEVEL_RST;
			cfg_q.detail_hold_ms  <= bidp_pkg::DETAIL_HOLD_MS_RST;
			cfg_q.idle_wait_ms    <= bidp_pkg::IDLE_WAIT_MS_RST;
			cfg_q.offline_wait_ms <= bidp_pkg::OFFLINE_WAIT_MS_RST;
		end else if (wr_en) begin
			unique case (bidp_pkg::reg_idx_t'(reg_sel))
				bidp_pkg::REG_ACTIVE_LEVEL:    cfg_q.active_level    <= pwdata[6:0];
				bidp_pkg::REG_IDLE_LEVEL:      cfg_q.idle_level      <= pwdata[6:0];
				bidp_pkg::REG_OFFLINE_LEVEL:   cfg_q.offline_level   <= pwdata[6:0];
				bidp_pkg::REG_DETAIL_HOLD_MS:  cfg_q.detail_hold_ms  <= pwdata;
				bidp_pkg::REG_IDLE_WAIT_MS:    cfg_q.idle_wait_ms    <= pwdata;
				bidp_pkg::REG_OFFLINE_WAIT_MS: cfg_q.offline_wait_ms <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (bidp_pkg::reg_idx_t'(reg_sel))
			bidp_pkg::REG_ACTIVE_LEVEL:    prdata = {25'd0, cfg_q.active_level};
			bidp_pkg::REG_IDLE_LEVEL:      prdata = {25'd0, cfg_q.idle_level};
			bidp_pkg::REG_OFFLINE_LEVEL:   prdata = {25'd0, cfg_q.offline_level};
			bidp_pkg::REG_DETAIL_HOLD_MS:  prdata = cfg_q.detail_hold_ms;
			bidp_pkg::REG_IDLE_WAIT_MS:    prdata = cfg_q.idle_wait_ms;
			bidp_pkg::REG_OFFLINE_WAIT_MS: prdata = cfg_q.offline_wait_ms;
			default:                       prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/bidp_policy.sv
// Policy state registers and the combinational next-state update for each event.
module bidp_policy (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  bidp_pkg::item_t     item,
	input  bidp_pkg::cfg_t      cfg,
	output bidp_pkg::result_t   res
);

	logic [bidp_pkg::TIME_BITS-1:0] last_active_q;
	logic [bidp_pkg::LEVEL_W-1:0]   level_q;
	logic                           open_q;
	logic [bidp_pkg::TIME_BITS-1:0] opened_at_q;

	logic [bidp_pkg::TIME_BITS-1:0] last_active_n;
	logic [bidp_pkg::LEVEL_W-1:0]   level_n;
	logic                           open_n;
	logic [bidp_pkg::TIME_BITS-1:0] opened_at_n;
	logic [bidp_pkg::LEVEL_W-1:0]   target;
	logic                           lvl_chg;
	logic                           view_chg;

	logic wake_chg;
	logic hold_done;
	logic idle_done;
	logic offline_done;

	assign wake_chg     = level_q != cfg.active_level;
	assign hold_done    = bidp_pkg::waited(item.now_ms, opened_at_q, cfg.detail_hold_ms);
	assign idle_done    = bidp_pkg::waited(item.now_ms, last_active_q, cfg.idle_wait_ms);
	assign offline_done = bidp_pkg::waited(item.now_ms, last_active_q, cfg.offline_wait_ms);

	always_comb begin
		last_active_n = last_active_q;
		level_n       = level_q;
		open_n        = open_q;
		opened_at_n   = opened_at_q;
		target        = cfg.active_level;
		lvl_chg       = 1'b0;
		view_chg      = 1'b0;
		case (item.kind)
			bidp_pkg::KIND_RESTART: begin
				lvl_chg       = wake_chg;
				level_n       = cfg.active_level;
				view_chg      = open_q;
				open_n        = 1'b0;
				opened_at_n   = '0;
				last_active_n = item.now_ms;
			end
			bidp_pkg::KIND_SNAPSHOT: begin
				last_active_n = item.now_ms;
				lvl_chg       = wake_chg;
				level_n       = cfg.active_level;
				if (open_q && !item.detail_present) begin
					open_n      = 1'b0;
					opened_at_n = '0;
					view_chg    = 1'b1;
				end
			end
			bidp_pkg::KIND_TAP: begin
				last_active_n = item.now_ms;
				// a tap on a dimmed screen only wakes it
				if (wake_chg) begin
					level_n = cfg.active_level;
					lvl_chg = 1'b1;
				end else if (item.in_region && item.detail_present) begin
					open_n      = !open_q;
					opened_at_n = open_q ? '0 : item.now_ms;
					view_chg    = 1'b1;
				end
			end
			bidp_pkg::KIND_ACTIVITY: begin
				last_active_n = item.now_ms;
				lvl_chg       = wake_chg;
				level_n       = cfg.active_level;
			end
			bidp_pkg::KIND_TICK: begin
				if (open_q && hold_done) begin
					open_n      = 1'b0;
					opened_at_n = '0;
					view_chg    = 1'b1;
				end
				if (!item.link_up && offline_done) begin
					target = cfg.offline_level;
				end else if (item.link_up && item.agent_idle && idle_done) begin
					target = cfg.idle_level;
				end
				if (target != level_q) begin
					level_n = target;
					lvl_chg = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_active_q <= '0;
			level_q       <= bidp_pkg::ACTIVE_LEVEL_RST;
			open_q        <= 1'b0;
			opened_at_q   <= '0;
		end else if (step) begin
			last_active_q <= last_active_n;
			level_q       <= level_n;
			open_q        <= open_n;
			opened_at_q   <= opened_at_n;
		end
	end

	assign res.level_changed = lvl_chg;
	assign res.view_changed  = view_chg;
	assign res.level_now     = level_n;
	assign res.detail_shown  = open_n;
	assign res.dim_opacity   = bidp_pkg::opacity_of(level_n);

endmodule

// File: rtl/core/backlight_idle_dimming_policy_core.sv
// Top level of the backlight idle dimming policy: stream ports, input and result registers.
// Takes one event per clock: an event is captured in the input register, then applied to
// the policy state as its result is loaded into the result register for the master side.
// Throughput is one event per cycle, set by the state update (three 48-bit compares and
// level/opacity logic), dropping only while m_tready low holds the result register. The
// user must write configuration over APB only while idle; the block does not enforce it.
module backlight_idle_dimming_policy_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [47:0] now_ms, [48] detail_present, [49] in_region, [50] link_up, [51] agent_idle
	input  logic [bidp_pkg::IN_DATA_W-1:0]   s_tdata,
	// [2:0] kind
	input  logic [bidp_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] level_changed, [1] view_changed, [8:2] level_now, [9] detail_shown,
	// [17:10] dim_opacity
	output logic [bidp_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bidp_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bidp_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bidp_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);

	bidp_pkg::cfg_t    cfg;
	bidp_pkg::item_t   item_in;
	bidp_pkg::item_t   item_s1;
	bidp_pkg::result_t res;
	bidp_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              in_take;
	logic              advance;

	assign item_in.kind           = s_tuser;
	assign item_in.now_ms         = s_tdata[bidp_pkg::TIME_BITS-1:0];
	assign item_in.detail_present = s_tdata[48];
	assign item_in.in_region      = s_tdata[49];
	assign item_in.link_up        = s_tdata[50];
	assign item_in.agent_idle     = s_tdata[51];

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	bidp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bidp_policy u_policy (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.dim_opacity, res_s2.detail_shown, res_s2.level_now,
		res_s2.view_changed, res_s2.level_changed};

endmodule

// File: rtl/core/bidp_checker.sv
// Port-level checker for the dimming policy core, bound to the top level.
module bidp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [bidp_pkg::IN_DATA_W-1:0]   s_tdata,
	input logic [bidp_pkg::IN_USER_W-1:0]   s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [bidp_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [bidp_pkg::APB_ADDR_W-1:0]  paddr,
	input logic [bidp_pkg::APB_DATA_W-1:0]  pwdata,
	input logic [bidp_pkg::APB_DATA_W-1:0]  prdata,
	input logic                             pready
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// the input side only backs up when the result register is full and stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with room downstream");

	// full (or above) level means no dimming overlay
	a_opac_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[8:2] >= bidp_pkg::LEVEL_FULL) |-> m_tdata[17:10] == 8'd0)
		else $error("opacity nonzero at full level");

	// dark backlight means an opaque overlay
	a_opac_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[8:2] == 7'd0) |-> m_tdata[17:10] == 8'd255)
		else $error("opacity not opaque at level zero");

endmodule

bind backlight_idle_dimming_policy_core bidp_checker u_bidp_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the backlight idle dimming policy core: directed table, then random events.
module testbench;
	import bidp_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int LAST_PHASE      = 6;
	localparam int BUSY_PCT        = 27;

	// kind codes the block does not define
	localparam logic [2:0] KIND_UNUSED_A = 3'd5;
	localparam logic [2:0] KIND_UNUSED_B = 3'd6;
	localparam logic [2:0] KIND_UNUSED_C = 3'd7;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [IN_USER_W-1:0]  s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	typedef struct packed {
		item_t   ev;
		logic    typed;
		result_t want;
	} dir_row_t;

	dir_row_t directed_rows[$];
	result_t  expected_results[$];

	// predictor copy of configuration and policy state
	cfg_t                 cur_cfg;
	logic [TIME_BITS-1:0] active_since;
	logic [LEVEL_W-1:0]   cur_level;
	logic                 view_open;
	logic [TIME_BITS-1:0] view_opened_at;

	logic [TIME_BITS-1:0] clock_ms     = '0;
	int unsigned          step_max     = 100;
	int                   gap_pct      = BUSY_PCT;
	int                   stall_pct    = BUSY_PCT;
	int                   fail_count   = 0;
	int                   result_seq   = 0;
	int unsigned          cycle_count  = 0;

	backlight_idle_dimming_policy_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got 0x%0h expected 0x%0h (t=%0t)", what, got, want, $time);
		fail_count++;
	endtask

	function automatic logic timeout_hit(input logic [TIME_BITS-1:0] now_t,
		input logic [TIME_BITS-1:0] start_t, input logic [WAIT_W-1:0] span);
		return (now_t >= start_t) &&
			((now_t - start_t) >= {{(TIME_BITS-WAIT_W){1'b0}}, span});
	endfunction

	function automatic logic [OPAC_W-1:0] dim_for(input logic [LEVEL_W-1:0] lv);
		int l;
		l = (lv > 100) ? 100 : int'(lv);
		return OPAC_W'(((100 - l) * 255 + 50) / 100);
	endfunction

	function automatic logic restore_active();
		if (cur_level != cur_cfg.active_level) begin
			cur_level = cur_cfg.active_level;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic result_t policy_step(input item_t ev);
		result_t            res;
		logic [LEVEL_W-1:0] target;
		res = '0;
		case (ev.kind)
		KIND_RESTART: begin
			res.level_changed = restore_active();
			res.view_changed = view_open;
			view_open = 1'b0;
			view_opened_at = '0;
			active_since = ev.now_ms;
		end
		KIND_SNAPSHOT: begin
			active_since = ev.now_ms;
			res.level_changed = restore_active();
			if (view_open && !ev.detail_present) begin
				view_open = 1'b0;
				view_opened_at = '0;
				res.view_changed = 1'b1;
			end
		end
		KIND_TAP: begin
			active_since = ev.now_ms;
			if (restore_active()) begin
				res.level_changed = 1'b1;
			end else if (ev.in_region && ev.detail_present) begin
				view_open = !view_open;
				view_opened_at = view_open ? ev.now_ms : '0;
				res.view_changed = 1'b1;
			end
		end
		KIND_ACTIVITY: begin
			active_since = ev.now_ms;
			res.level_changed = restore_active();
		end
		KIND_TICK: begin
			target = cur_cfg.active_level;
			if (view_open && timeout_hit(ev.now_ms, view_opened_at, cur_cfg.detail_hold_ms)) begin
				view_open = 1'b0;
				view_opened_at = '0;
				res.view_changed = 1'b1;
			end
			if (!ev.link_up && timeout_hit(ev.now_ms, active_since, cur_cfg.offline_wait_ms))
				target = cur_cfg.offline_level;
			else if (ev.link_up && ev.agent_idle &&
				timeout_hit(ev.now_ms, active_since, cur_cfg.idle_wait_ms))
				target = cur_cfg.idle_level;
			if (target != cur_level) begin
				cur_level = target;
				res.level_changed = 1'b1;
			end
		end
		default: ;
		endcase
		res.level_now = cur_level;
		res.detail_shown = view_open;
		res.dim_opacity = dim_for(cur_level);
		return res;
	endfunction

	// APB write, then read back and compare
	task automatic program_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] kept;
		kept = (idx <= REG_OFFLINE_LEVEL) ? {25'd0, value[6:0]} : value;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
		REG_ACTIVE_LEVEL:    cur_cfg.active_level = value[6:0];
		REG_IDLE_LEVEL:      cur_cfg.idle_level = value[6:0];
		REG_OFFLINE_LEVEL:   cur_cfg.offline_level = value[6:0];
		REG_DETAIL_HOLD_MS:  cur_cfg.detail_hold_ms = value;
		REG_IDLE_WAIT_MS:    cur_cfg.idle_wait_ms = value;
		REG_OFFLINE_WAIT_MS: cur_cfg.offline_wait_ms = value;
		default: ;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== kept)
			flag_mismatch("register readback", prdata, kept);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_policy(input logic [31:0] act, input logic [31:0] idl,
		input logic [31:0] off, input logic [31:0] hold, input logic [31:0] iwait,
		input logic [31:0] owait);
		program_reg(REG_ACTIVE_LEVEL, act);
		program_reg(REG_IDLE_LEVEL, idl);
		program_reg(REG_OFFLINE_LEVEL, off);
		program_reg(REG_DETAIL_HOLD_MS, hold);
		program_reg(REG_IDLE_WAIT_MS, iwait);
		program_reg(REG_OFFLINE_WAIT_MS, owait);
	endtask

	// mostly 0..100, sometimes above; junk in the upper bits checks the masking
	function automatic logic [31:0] rand_level();
		logic [6:0] lv;
		lv = ($urandom_range(9) == 0) ? 7'($urandom_range(101, 127)) : 7'($urandom_range(100));
		return {25'($urandom()), lv};
	endfunction

	task automatic dir_row(input logic [2:0] kind, input logic [TIME_BITS-1:0] now,
		input logic dp, input logic rg, input logic lk, input logic ai, input logic typed,
		input logic lc, input logic vc, input logic [6:0] lvl, input logic shown,
		input logic [7:0] op);
		dir_row_t row;
		row.ev.kind = kind;
		row.ev.now_ms = now;
		row.ev.detail_present = dp;
		row.ev.in_region = rg;
		row.ev.link_up = lk;
		row.ev.agent_idle = ai;
		row.typed = typed;
		row.want.level_changed = lc;
		row.want.view_changed = vc;
		row.want.level_now = lvl;
		row.want.detail_shown = shown;
		row.want.dim_opacity = op;
		directed_rows.push_back(row);
	endtask

	task automatic make_event(output item_t ev);
		int unsigned          r;
		logic [TIME_BITS-1:0] t;
		r = $urandom_range(99);
		if (r < 8)
			ev.kind = KIND_RESTART;
		else if (r < 22)
			ev.kind = KIND_SNAPSHOT;
		else if (r < 44)
			ev.kind = KIND_TAP;
		else if (r < 54)
			ev.kind = KIND_ACTIVITY;
		else if (r < 94)
			ev.kind = KIND_TICK;
		else
			ev.kind = KIND_UNUSED_A + 3'($urandom_range(2));
		r = $urandom_range(99);
		if (r < 75) begin
			clock_ms = clock_ms + TIME_BITS'($urandom_range(step_max));
			t = clock_ms;
		end else if (r < 85) begin
			// long jump, a random 34-bit step that can pass the widest wait
			clock_ms = clock_ms + TIME_BITS'({2'($urandom_range(3)), $urandom()});
			t = clock_ms;
		end else if (r < 92) begin
			// stale timestamp, the running clock is kept
			t = clock_ms - TIME_BITS'($urandom_range(step_max)) - 1'b1;
		end else if (r < 97) begin
			clock_ms = {16'($urandom()), $urandom()};
			t = clock_ms;
		end else begin
			clock_ms = '1 - TIME_BITS'($urandom_range(step_max));
			t = clock_ms;
		end
		ev.now_ms = t;
		ev.detail_present = ($urandom_range(99) < 75);
		ev.in_region = ($urandom_range(99) < 75);
		ev.link_up = ($urandom_range(99) < 60);
		ev.agent_idle = ($urandom_range(99) < 60);
	endtask

	task automatic send_event(input item_t ev, input logic typed, input result_t want);
		result_t pred;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, ev.agent_idle, ev.link_up, ev.in_region, ev.detail_present,
			ev.now_ms};
		s_tuser <= ev.kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = policy_step(ev);
		expected_results.push_back(typed ? want : pred);
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		result_t got;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= stall_pct);
			if (m_tvalid && m_tready) begin
				got.level_changed = m_tdata[0];
				got.view_changed = m_tdata[1];
				got.level_now = m_tdata[8:2];
				got.detail_shown = m_tdata[9];
				got.dim_opacity = m_tdata[17:10];
				result_seq++;
				if (expected_results.size() == 0) begin
					flag_mismatch("result with nothing pending", 32'(m_tdata), 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (got.level_changed !== want.level_changed)
						flag_mismatch("level_changed", 32'(got.level_changed),
							32'(want.level_changed));
					if (got.view_changed !== want.view_changed)
						flag_mismatch("view_changed", 32'(got.view_changed),
							32'(want.view_changed));
					if (got.level_now !== want.level_now)
						flag_mismatch("level_now", 32'(got.level_now), 32'(want.level_now));
					if (got.detail_shown !== want.detail_shown)
						flag_mismatch("detail_shown", 32'(got.detail_shown),
							32'(want.detail_shown));
					if (got.dim_opacity !== want.dim_opacity)
						flag_mismatch("dim_opacity", 32'(got.dim_opacity),
							32'(want.dim_opacity));
				end
			end
		end
	end

	initial begin : stimulus
		item_t   ev;
		result_t none;
		int      ph;
		none = '0;
		cur_cfg.active_level = ACTIVE_LEVEL_RST;
		cur_cfg.idle_level = IDLE_LEVEL_RST;
		cur_cfg.offline_level = OFFLINE_LEVEL_RST;
		cur_cfg.detail_hold_ms = DETAIL_HOLD_MS_RST;
		cur_cfg.idle_wait_ms = IDLE_WAIT_MS_RST;
		cur_cfg.offline_wait_ms = OFFLINE_WAIT_MS_RST;
		active_since = '0;
		cur_level = ACTIVE_LEVEL_RST;
		view_open = 1'b0;
		view_opened_at = '0;

		// reset values: active 100, idle 30, offline 10, hold 10 s, waits 30 s / 60 s
		dir_row(KIND_TICK,     48'd0,     0, 0, 1, 0, 1, 0, 0, 100, 0, 0);
		dir_row(KIND_ACTIVITY, 48'd5,     0, 0, 0, 0, 1, 0, 0, 100, 0, 0);
		dir_row(KIND_TAP,      48'd100,   1, 1, 0, 0, 1, 0, 1, 100, 1, 0);
		dir_row(KIND_SNAPSHOT, 48'd200,   1, 0, 0, 0, 1, 0, 0, 100, 1, 0);
		dir_row(KIND_TICK,     48'd10099, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_TICK,     48'd10100, 0, 0, 1, 1, 1, 0, 1, 100, 0, 0);
		dir_row(KIND_TICK,     48'd30200, 0, 0, 1, 1, 1, 1, 0, 30, 0, 179);
		// tap while dimmed only wakes the backlight
		dir_row(KIND_TAP,      48'd30300, 1, 1, 0, 0, 1, 1, 0, 100, 0, 0);
		dir_row(KIND_TICK,     48'd90299, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_TICK,     48'd90300, 0, 0, 0, 1, 1, 1, 0, 10, 0, 230);
		// clock runs backwards: no timeout reached
		dir_row(KIND_TICK,     48'd1000,  0, 0, 0, 1, 1, 1, 0, 100, 0, 0);
		dir_row(KIND_TAP,      48'd2000,  1, 1, 0, 0, 1, 0, 1, 100, 1, 0);
		dir_row(KIND_TAP,      48'd2100,  0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_TAP,      48'd2200,  1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_TICK,     48'd1500,  0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_RESTART,  48'd3000,  0, 0, 0, 0, 1, 0, 1, 100, 0, 0);
		dir_row(KIND_TAP,      48'd3100,  1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_TAP,      48'd3150,  1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_TAP,      48'd3200,  1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_SNAPSHOT, 48'd3300,  0, 0, 0, 0, 1, 0, 1, 100, 0, 0);
		dir_row(KIND_UNUSED_A, '1,        1, 1, 1, 1, 1, 0, 0, 100, 0, 0);
		dir_row(KIND_UNUSED_B, 48'd7,     1, 1, 1, 1, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_UNUSED_C, 48'd9,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_ACTIVITY, '1,        1, 1, 1, 1, 1, 0, 0, 100, 0, 0);
		dir_row(KIND_TICK,     '1,        1, 1, 0, 1, 0, 0, 0, 0, 0, 0);
		dir_row(KIND_RESTART,  48'd0,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (ph = 0; ph <= LAST_PHASE; ph++) begin
			gap_pct = (ph == 5) ? 0 : BUSY_PCT;
			stall_pct = gap_pct;
			case (ph)
			0: ;
			1: begin
				load_policy(32'd0, 32'd100, 32'd127, 32'd0, 32'd0, 32'd0);
				step_max = 50;
			end
			2: begin
				load_policy(32'd127, 32'd0, 32'd0, '1, '1, '1);
				step_max = 1000;
			end
			3: begin
				load_policy(32'd100, 32'd30, 32'd10, 32'd10000, 32'd30000, 32'd60000);
				step_max = 20000;
			end
			default: begin
				load_policy(rand_level(), rand_level(), rand_level(), $urandom_range(4000),
					$urandom_range(4000), $urandom_range(4000));
				step_max = 1500;
			end
			endcase
			if (ph == 0) begin
				foreach (directed_rows[i])
					send_event(directed_rows[i].ev, directed_rows[i].typed,
						directed_rows[i].want);
			end else begin
				repeat (ITEMS_PER_PHASE) begin
					make_event(ev);
					send_event(ev, 1'b0, none);
				end
			end
			s_tvalid <= 1'b0;
			while (expected_results.size() != 0)
				@(posedge clk);
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
